[sv/spq_pkg.sv]
`timescale 1ns / 1ps

package spq_pkg;

  localparam int DEPTH = 64;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int POS_W = 6;
  localparam int CAP_W = 7;
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int LIM_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  typedef enum logic [2:0] {
    OP_ENQUEUE  = 3'd0,
    OP_DEQUEUE  = 3'd1,
    OP_PEEK     = 3'd2,
    OP_GET_POS  = 3'd3,
    OP_GET_PRIO = 3'd4,
    OP_CLEAR    = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_NONE = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

  typedef enum logic [1:0] {
    CM_HOLD,
    CM_INSERT,
    CM_SHIFT
  } cell_mode_t;

  typedef struct packed {
    logic [2:0]         operation;
    logic [31:0]        item_data;
    logic signed [15:0] item_priority;
    logic [POS_W-1:0]   position;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [31:0]        out_data;
    logic signed [15:0] out_priority;
    logic [CAP_W-1:0]   entry_count;
  } rsp_t;

  typedef struct packed {
    logic signed [15:0] prio;
    logic [31:0]        word;
  } entry_t;

  typedef struct packed {
    cell_mode_t mode;
    entry_t     fresh;
  } cell_ctrl_t;

endpackage

[sv/stable_priority_queue.sv]
`timescale 1ns / 1ps

// Stable priority queue held in a row of DEPTH cells, highest priority at the
// head, arrival order kept among equal priorities. Enqueue, dequeue, peek, clear
// and unused codes are handled without a scan: every cell compares its priority with the new
// one in parallel and either holds, takes the new entry or takes its neighbour's.
// Get by position and get by priority scan the row: it rotates once past the
// head cell while a counter picks the entry, and requests are held off meanwhile.
// Results sit in an output register, so a new request is taken in the cycle the
// previous result is collected, but is held off while that result is stalled.
module stable_priority_queue (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  spq_pkg::req_t             req,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output spq_pkg::rsp_t             rsp,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [spq_pkg::CAP_W-1:0] cfg_data
);

  localparam int DEPTH = spq_pkg::DEPTH;
  localparam int CNT_W = spq_pkg::CNT_W;
  localparam int IDX_W = spq_pkg::IDX_W;
  localparam int CMP_W = spq_pkg::CMP_W;
  localparam int LIM_W = spq_pkg::LIM_W;
  localparam int CAP_W = spq_pkg::CAP_W;
  localparam int POS_W = spq_pkg::POS_W;

  spq_pkg::state_t     state, state_next;
  logic [CNT_W-1:0]    count, count_next;
  logic [CAP_W-1:0]    capacity_limit;
  logic [IDX_W-1:0]    scan_idx, scan_idx_next;
  logic [CNT_W-1:0]    match, match_next;
  logic                found, found_next;
  spq_pkg::entry_t     found_entry, found_entry_next;
  logic [2:0]          scan_op;
  logic signed [15:0]  scan_prio;
  logic [POS_W-1:0]    scan_pos;
  spq_pkg::rsp_t       rsp_next;
  logic                rsp_load;
  logic                accept;
  logic                scan_last;
  logic                full;
  logic [LIM_W-1:0]    limit;

  spq_pkg::cell_ctrl_t ctrl;
  spq_pkg::entry_t     entries [DEPTH];
  logic [DEPTH-1:0]    ge;
  logic [DEPTH-1:0]    occupied;

  spq_pkg::entry_t     head;
  logic                head_occ;
  logic                prio_eq;
  logic                take;

  assign cfg_ready = 1'b1;
  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != spq_pkg::S_IDLE) || (rsp_valid && rsp_stall);
  assign scan_last = (scan_idx == IDX_W'(DEPTH - 1));

  assign limit = ((capacity_limit == '0) || (LIM_W'(capacity_limit) > LIM_W'(DEPTH)))
                 ? LIM_W'(DEPTH) : LIM_W'(capacity_limit);
  assign full  = (LIM_W'(count) >= limit);

  // cell row; the last cell takes the head back so a scan rotation restores the order
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign occupied[i] = (CNT_W'(i) < count);
    if (i == 0) begin : g_first
      spq_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .occupied    (occupied[i]),
        .left_ge     (1'b1),
        .left_entry  (ctrl.fresh),
        .right_entry (entries[(i + 1) % DEPTH]),
        .entry       (entries[i]),
        .ge          (ge[i])
      );
    end else begin : g_rest
      spq_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .occupied    (occupied[i]),
        .left_ge     (ge[i-1]),
        .left_entry  (entries[i-1]),
        .right_entry (entries[(i + 1) % DEPTH]),
        .entry       (entries[i]),
        .ge          (ge[i])
      );
    end
  end

  assign head     = entries[0];
  assign head_occ = (CNT_W'(scan_idx) < count);
  assign prio_eq  = (head.prio == scan_prio);
  assign take     = head_occ &&
                    ((scan_op == spq_pkg::OP_GET_POS)
                       ? (CMP_W'(scan_idx) == CMP_W'(scan_pos))
                       : (prio_eq && (CMP_W'(match) == CMP_W'(scan_pos))));

  always_comb begin
    state_next = state;
    case (state)
      spq_pkg::S_IDLE: begin
        if (accept && ((req.operation == spq_pkg::OP_GET_POS) ||
                       (req.operation == spq_pkg::OP_GET_PRIO))) begin
          state_next = spq_pkg::S_SCAN;
        end
      end
      spq_pkg::S_SCAN: begin
        if (scan_last) begin
          state_next = spq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = spq_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl.mode        = spq_pkg::CM_HOLD;
    ctrl.fresh.prio  = req.item_priority;
    ctrl.fresh.word  = req.item_data;
    count_next       = count;
    rsp_load         = 1'b0;
    rsp_next.status  = spq_pkg::ST_OK;
    rsp_next.out_data     = '0;
    rsp_next.out_priority = '0;
    scan_idx_next    = '0;
    match_next       = '0;
    found_next       = 1'b0;
    found_entry_next = found_entry;
    case (state)
      spq_pkg::S_IDLE: begin
        if (accept) begin
          rsp_load = 1'b1;
          case (req.operation)
            spq_pkg::OP_ENQUEUE: begin
              if (full) begin
                rsp_next.status = spq_pkg::ST_FULL;
              end else begin
                ctrl.mode  = spq_pkg::CM_INSERT;
                count_next = count + CNT_W'(1);
              end
            end
            spq_pkg::OP_DEQUEUE, spq_pkg::OP_PEEK: begin
              if (count == '0) begin
                rsp_next.status = spq_pkg::ST_NONE;
              end else begin
                rsp_next.out_data     = head.word;
                rsp_next.out_priority = head.prio;
                if (req.operation == spq_pkg::OP_DEQUEUE) begin
                  ctrl.mode  = spq_pkg::CM_SHIFT;
                  count_next = count - CNT_W'(1);
                end
              end
            end
            spq_pkg::OP_GET_POS, spq_pkg::OP_GET_PRIO: begin
              rsp_load = 1'b0;
            end
            spq_pkg::OP_CLEAR: begin
              count_next = '0;
            end
            default: begin
              rsp_next.status = spq_pkg::ST_OK;
            end
          endcase
        end
      end
      spq_pkg::S_SCAN: begin
        ctrl.mode     = spq_pkg::CM_SHIFT;
        scan_idx_next = scan_idx + IDX_W'(1);
        match_next    = match + CNT_W'(head_occ && prio_eq);
        found_next    = found || take;
        if (take) begin
          found_entry_next = head;
        end
        if (scan_last) begin
          rsp_load = 1'b1;
          if (found_next) begin
            rsp_next.out_data     = found_entry_next.word;
            rsp_next.out_priority = found_entry_next.prio;
          end else begin
            rsp_next.status = spq_pkg::ST_NONE;
          end
        end
      end
      default: begin
        ctrl.mode = spq_pkg::CM_HOLD;
      end
    endcase
    rsp_next.entry_count = CAP_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= spq_pkg::S_IDLE;
      count          <= '0;
      capacity_limit <= '0;
      rsp_valid      <= 1'b0;
      scan_idx       <= '0;
      match          <= '0;
      found          <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      scan_idx <= scan_idx_next;
      match    <= match_next;
      found    <= found_next;
      if (cfg_valid && cfg_ready) begin
        capacity_limit <= cfg_data;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    found_entry <= found_entry_next;
    if (rsp_load) begin
      rsp <= rsp_next;
    end
    if (accept) begin
      scan_op   <= req.operation;
      scan_prio <= req.item_priority;
      scan_pos  <= req.position;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    LIM_W'(count) <= LIM_W'(DEPTH))
    else $error("entry count beyond depth");

  a_scan_stalls: assert property (@(posedge clk) disable iff (rst)
    (state == spq_pkg::S_SCAN) |-> (req_stall && !rsp_valid))
    else $error("request taken or result pending during scan");

  a_scan_count: assert property (@(posedge clk) disable iff (rst)
    (state == spq_pkg::S_SCAN) |=> $stable(count))
    else $error("count changed by a scan");

  a_scan_result: assert property (@(posedge clk) disable iff (rst)
    (state == spq_pkg::S_SCAN && scan_last) |=> (rsp_valid && state == spq_pkg::S_IDLE))
    else $error("scan ended without a result");

endmodule

[sv/spq_cell.sv]
`timescale 1ns / 1ps

module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  logic               occupied,
  input  logic               left_ge,
  input  spq_pkg::entry_t    left_entry,
  input  spq_pkg::entry_t    right_entry,
  output spq_pkg::entry_t    entry,
  output logic               ge
);

  spq_pkg::entry_t entry_next;

  // entries at or above the new priority stay put; sorted order makes ge a prefix
  assign ge = occupied && (entry.prio >= ctrl.fresh.prio);

  always_comb begin
    entry_next = entry;
    case (ctrl.mode)
      spq_pkg::CM_INSERT: begin
        if (ge) begin
          entry_next = entry;
        end else if (left_ge) begin
          entry_next = ctrl.fresh;
        end else begin
          entry_next = left_entry;
        end
      end
      spq_pkg::CM_SHIFT: begin
        entry_next = right_entry;
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule
